[rtl/timed_playback_request_queue_macros.svh]
// Assertion helpers shared by the RTL of the playback request queue.
`ifndef TIMED_PLAYBACK_REQUEST_QUEUE_MACROS_SVH
`define TIMED_PLAYBACK_REQUEST_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tprq_pkg.sv]
`timescale 1ns / 1ps

package tprq_pkg;

    localparam int CLIP_W  = 5;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;
    localparam int COUNT_MAX = 31;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CLIP_W-1:0] clip_number;
        logic [TIME_W-1:0] now_ms;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               play_start;
        logic [CLIP_W-1:0]  play_clip;
        logic [COUNT_W-1:0] queued_count;
    } rsp_item_t;

    // Operation codes.
    localparam logic [1:0] OP_WARNING = 2'd0;
    localparam logic [1:0] OP_ALARM   = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_RATE    = 3'd3;
    localparam logic [2:0] ST_STARTED = 3'd4;
    localparam logic [2:0] ST_PLAYING = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PLAY_DURATION = 2'd0;
    localparam logic [1:0] REG_ALARM_REPEAT  = 2'd1;
    localparam logic [1:0] REG_MAX_TRACK     = 2'd2;
    localparam logic [1:0] REG_ALARM_TRACK   = 2'd3;

    localparam logic [TIME_W-1:0] PLAY_DURATION_RST = 32'd8000;
    localparam logic [TIME_W-1:0] ALARM_REPEAT_RST  = 32'd8000;
    localparam logic [CLIP_W-1:0] MAX_TRACK_RST     = 5'd20;
    localparam logic [CLIP_W-1:0] ALARM_TRACK_RST   = 5'd1;

endpackage

[rtl/tprq_ram.sv]
`timescale 1ns / 1ps

module tprq_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/timed_playback_request_queue.sv]
// Channel   | Direction | Handshake        | Payload
// request   | in        | req_valid/stall  | req_data (operation, clip_number, now_ms)
// response  | out       | rsp_valid/stall  | rsp_data (status, play_start, play_clip, count)
// config    | in        | APB write/read   | paddr[3:2] selects one of four registers
//
// One request is taken every cycle unless req_stall holds it; its response passes
// through the input register and then the result register around the logic before
// it is valid on the response channel.
// The clip ring is a RAM with a registered read port; a one-entry bypass covers
// a pop that follows directly on a push into an empty ring.
// Reset clears the ring pointers, the playing flag, both time stamps and restores
// the register defaults; the clip store itself is not cleared.
// A stalled response holds the result register; requests stall only once the
// input register is also occupied.
`timescale 1ns / 1ps
`include "timed_playback_request_queue_macros.svh"

module timed_playback_request_queue #(
    parameter int QUEUE_SLOTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  tprq_pkg::req_item_t  req_data,

    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tprq_pkg::rsp_item_t  rsp_data,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import tprq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam int CW    = PTR_W + 5;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    // Configuration registers.
    logic [TIME_W-1:0] play_duration_reg;
    logic [TIME_W-1:0] alarm_repeat_reg;
    logic [CLIP_W-1:0] max_track_reg;
    logic [CLIP_W-1:0] alarm_track_reg;

    // Pipeline registers.
    logic       proc_valid_reg;
    req_item_t  proc_item_reg;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_item_reg;

    // Queue and timing state.
    logic [PTR_W-1:0]  read_slot_reg, read_slot_next;
    logic [PTR_W-1:0]  write_slot_reg, write_slot_next;
    logic              playing_reg;
    logic [TIME_W-1:0] play_start_reg;
    logic [TIME_W-1:0] last_alarm_reg;
    logic              bypass_reg, bypass_next;
    logic [CLIP_W-1:0] bypass_data_reg;

    logic              advance;
    logic              req_accept;
    logic              cfg_write;

    logic [PTR_W-1:0]  read_inc;
    logic [PTR_W-1:0]  write_inc;
    logic              ring_full;
    logic              ring_empty;
    logic              alarm_due;
    logic              still_playing;
    logic              clip_ok;
    logic [CLIP_W-1:0] head_clip;
    logic [CLIP_W-1:0] ram_rdata;

    logic              push_en;
    logic              pop_en;
    logic              alarm_take;
    logic              stop_play;
    logic [CLIP_W-1:0] push_clip;
    logic [2:0]        status;
    logic [CW-1:0]     depth_w;
    rsp_item_t         result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign advance    = proc_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = proc_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_duration_reg <= PLAY_DURATION_RST;
            alarm_repeat_reg  <= ALARM_REPEAT_RST;
            max_track_reg     <= MAX_TRACK_RST;
            alarm_track_reg   <= ALARM_TRACK_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PLAY_DURATION: play_duration_reg <= pwdata;
                REG_ALARM_REPEAT:  alarm_repeat_reg  <= pwdata;
                REG_MAX_TRACK:     max_track_reg     <= pwdata[CLIP_W-1:0];
                REG_ALARM_TRACK:   alarm_track_reg   <= pwdata[CLIP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PLAY_DURATION: prdata = play_duration_reg;
            REG_ALARM_REPEAT:  prdata = alarm_repeat_reg;
            REG_MAX_TRACK:     prdata = 32'(max_track_reg);
            REG_ALARM_TRACK:   prdata = 32'(alarm_track_reg);
            default:           prdata = '0;
        endcase
    end

    // Ring bookkeeping for the request in the input register.
    assign read_inc   = (read_slot_reg == LAST_SLOT) ? '0 : read_slot_reg + 1'b1;
    assign write_inc  = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
    assign ring_full  = (write_inc == read_slot_reg);
    assign ring_empty = (read_slot_reg == write_slot_reg);

    assign alarm_due     = (proc_item_reg.now_ms - last_alarm_reg) >= alarm_repeat_reg;
    assign still_playing = playing_reg
                           && ((proc_item_reg.now_ms - play_start_reg) < play_duration_reg);
    assign clip_ok       = (proc_item_reg.clip_number != '0)
                           && (proc_item_reg.clip_number <= max_track_reg);
    assign head_clip     = bypass_reg ? bypass_data_reg : ram_rdata;

    always_comb
    begin
        push_en    = 1'b0;
        pop_en     = 1'b0;
        alarm_take = 1'b0;
        stop_play  = 1'b0;
        push_clip  = proc_item_reg.clip_number;
        status     = ST_INVALID;
        case (proc_item_reg.operation)
            OP_WARNING:
            begin
                if (!clip_ok)
                begin
                    status = ST_INVALID;
                end
                else if (ring_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    push_en = 1'b1;
                    status  = ST_QUEUED;
                end
            end
            OP_ALARM:
            begin
                push_clip = alarm_track_reg;
                if (!alarm_due)
                begin
                    status = ST_RATE;
                end
                else
                begin
                    // The alarm counts as taken even when the ring is full.
                    alarm_take = 1'b1;
                    if (ring_full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        status  = ST_QUEUED;
                    end
                end
            end
            OP_SERVICE:
            begin
                if (still_playing)
                begin
                    status = ST_PLAYING;
                end
                else if (!ring_empty)
                begin
                    pop_en = 1'b1;
                    status = ST_STARTED;
                end
                else
                begin
                    stop_play = 1'b1;
                    status    = ST_EMPTY;
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    assign write_slot_next = (advance && push_en) ? write_inc : write_slot_reg;
    assign read_slot_next  = (advance && pop_en) ? read_inc : read_slot_reg;

    // A write landing on the address being read is forwarded while the RAM read still returns the old contents.
    assign bypass_next = advance && push_en && (write_slot_reg == read_slot_next);

    assign depth_w = CW'(write_slot_next)
                     + ((write_slot_next < read_slot_next) ? CW'(QUEUE_SLOTS) : '0)
                     - CW'(read_slot_next);

    always_comb
    begin
        result.status       = status;
        result.play_start   = pop_en;
        result.play_clip    = pop_en ? head_clip : '0;
        result.queued_count = (depth_w > CW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : depth_w[COUNT_W-1:0];
    end

    tprq_ram #(
        .WIDTH (CLIP_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_clip_ram (
        .clk   (clk),
        .we    (advance && push_en),
        .waddr (write_slot_reg),
        .wdata (push_clip),
        .raddr (read_slot_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
            playing_reg    <= 1'b0;
            play_start_reg <= '0;
            last_alarm_reg <= '0;
            bypass_reg     <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                proc_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                proc_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            bypass_reg     <= bypass_next;

            if (advance && alarm_take)
            begin
                last_alarm_reg <= proc_item_reg.now_ms;
            end
            if (advance && pop_en)
            begin
                playing_reg    <= 1'b1;
                play_start_reg <= proc_item_reg.now_ms;
            end
            else if (advance && stop_play)
            begin
                playing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            proc_item_reg <= req_data;
        end
        if (advance)
        begin
            rsp_item_reg <= result;
        end
        bypass_data_reg <= push_clip;
    end

    `TPRQ_ASSERT_NEXT(a_push_not_empty, advance && push_en, read_slot_reg != write_slot_reg, "push left the ring empty")
    `TPRQ_ASSERT_SAME(a_pop_not_empty, advance && pop_en, !ring_empty, "pop from an empty ring")
    `TPRQ_ASSERT_NEXT(a_pop_plays, advance && pop_en, playing_reg, "started clip not flagged as playing")
    `TPRQ_ASSERT_SAME(a_bypass_slot, bypass_reg, read_slot_reg == $past(write_slot_reg), "bypass does not match the head slot")
    `TPRQ_ASSERT_NEXT(a_stall_holds, req_stall, proc_valid_reg && $stable(proc_item_reg), "held request changed")

endmodule
